// File: design/btaa_pkg.sv
package btaa_pkg;

  // Default pool size exponent: 2^ADDR_BITS addresses
  localparam int ADDR_BITS_DEF = 8;

  // Field widths of the stream payload
  localparam int ADDR_FIELD_W  = 8;
  localparam int STATUS_W      = 2;
  localparam int COUNT_FIELD_W = 9;
  localparam int OUT_DATA_W    = 24;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 2'd2;

  // Request handed to the tree engine
  typedef struct packed {
    logic                    op;
    logic [ADDR_FIELD_W-1:0] address;
  } req_t;

  // Answer returned by the tree engine
  typedef struct packed {
    logic                    op;
    logic [STATUS_W-1:0]     status;
    logic [ADDR_FIELD_W-1:0] granted;
  } rsp_t;

endpackage

// File: design/btaa_engine.sv
module btaa_engine #(
  parameter int ADDR_BITS = btaa_pkg::ADDR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  input  btaa_pkg::req_t  req,
  output logic            req_ready,
  output logic            rsp_valid,
  output btaa_pkg::rsp_t  rsp,
  input  logic            rsp_take
);

  // Node index in a 1-based heap: root 1, leaves at 2^ADDR_BITS + address
  localparam int NW    = ADDR_BITS + 1;
  localparam int DEPTH = 2 ** NW;
  localparam int XW    = (ADDR_BITS > btaa_pkg::ADDR_FIELD_W) ? ADDR_BITS
                                                              : btaa_pkg::ADDR_FIELD_W;

  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_LEAF_CHK  = 4'd2;
  localparam logic [3:0] S_CLIMB     = 4'd3;
  localparam logic [3:0] S_CLIMB_CHK = 4'd4;
  localparam logic [3:0] S_DESC      = 4'd5;
  localparam logic [3:0] S_DESC_CHK  = 4'd6;
  localparam logic [3:0] S_SIB_RD    = 4'd7;
  localparam logic [3:0] S_PAR_WR    = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  // Full marks of all nodes, leaves included (entry 0 unused)
  logic tree_mem_r [DEPTH];
  logic rd_data_r;

  logic [3:0]                          state_r, state_nxt;
  logic [NW-1:0]                       clr_r, clr_nxt;
  logic [NW-1:0]                       node_r, node_nxt;
  logic                                val_r, val_nxt;
  logic                                op_r, op_nxt;
  logic [btaa_pkg::STATUS_W-1:0]       status_r, status_nxt;
  logic [btaa_pkg::ADDR_FIELD_W-1:0]   granted_r, granted_nxt;

  logic          we;
  logic [NW-1:0] wa;
  logic          wd;
  logic [NW-1:0] rd_addr;
  logic [XW-1:0] addr_ext;
  logic          par_full;

  // Sequencer: an alloc climbs for a free right sibling and descends to its
  // leftmost free leaf, a release frees its leaf; both refresh the full marks to the root
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    node_nxt    = node_r;
    val_nxt     = val_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    granted_nxt = granted_r;
    we          = 1'b0;
    wa          = node_r;
    wd          = 1'b0;
    rd_addr     = node_r;
    addr_ext    = XW'(req.address);
    par_full    = val_r & rd_data_r;

    case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wa      = clr_r;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = {1'b1, addr_ext[ADDR_BITS-1:0]};
        if (req_valid) begin
          op_nxt      = req.op;
          status_nxt  = btaa_pkg::ST_OK;
          granted_nxt = '0;
          node_nxt    = {1'b1, addr_ext[ADDR_BITS-1:0]};
          if ((addr_ext >> ADDR_BITS) != '0) begin
            status_nxt = (req.op == btaa_pkg::OP_ALLOC) ? btaa_pkg::ST_NO_FREE
                                                        : btaa_pkg::ST_NOT_TAKEN;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_LEAF_CHK;
          end
        end
      end
      S_LEAF_CHK: begin
        if (op_r == btaa_pkg::OP_ALLOC) begin
          if (!rd_data_r) begin
            we          = 1'b1;
            wd          = 1'b1;
            val_nxt     = 1'b1;
            granted_nxt = btaa_pkg::ADDR_FIELD_W'(node_r[ADDR_BITS-1:0]);
            state_nxt   = S_SIB_RD;
          end else begin
            state_nxt = S_CLIMB;
          end
        end else if (rd_data_r) begin
          we        = 1'b1;
          wd        = 1'b0;
          val_nxt   = 1'b0;
          state_nxt = S_SIB_RD;
        end else begin
          status_nxt = btaa_pkg::ST_NOT_TAKEN;
          state_nxt  = S_DONE;
        end
      end
      S_CLIMB: begin
        if (node_r == NW'(1)) begin
          status_nxt = btaa_pkg::ST_NO_FREE;
          state_nxt  = S_DONE;
        end else if (!node_r[0]) begin
          rd_addr   = node_r + NW'(1);
          state_nxt = S_CLIMB_CHK;
        end else begin
          node_nxt = node_r >> 1;
        end
      end
      S_CLIMB_CHK: begin
        if (!rd_data_r) begin
          node_nxt  = node_r + NW'(1);
          state_nxt = S_DESC;
        end else begin
          node_nxt  = node_r >> 1;
          state_nxt = S_CLIMB;
        end
      end
      S_DESC: begin
        if (node_r[ADDR_BITS]) begin
          we          = 1'b1;
          wd          = 1'b1;
          val_nxt     = 1'b1;
          granted_nxt = btaa_pkg::ADDR_FIELD_W'(node_r[ADDR_BITS-1:0]);
          state_nxt   = S_SIB_RD;
        end else begin
          rd_addr   = {node_r[ADDR_BITS-1:0], 1'b0};
          state_nxt = S_DESC_CHK;
        end
      end
      S_DESC_CHK: begin
        // left child full: go right
        node_nxt  = {node_r[ADDR_BITS-1:0], rd_data_r};
        state_nxt = S_DESC;
      end
      S_SIB_RD: begin
        rd_addr   = node_r ^ NW'(1);
        state_nxt = S_PAR_WR;
      end
      S_PAR_WR: begin
        we       = 1'b1;
        wa       = node_r >> 1;
        wd       = par_full;
        val_nxt  = par_full;
        node_nxt = node_r >> 1;
        if ((node_r >> 1) == NW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SIB_RD;
        end
      end
      S_DONE: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Tree memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      tree_mem_r[wa] <= wd;
    end
    rd_data_r <= tree_mem_r[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    val_r     <= val_nxt;
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
  end

  assign req_ready   = (state_r == S_IDLE);
  assign rsp_valid   = (state_r == S_DONE);
  assign rsp.op      = op_r;
  assign rsp.status  = status_r;
  assign rsp.granted = granted_r;

endmodule

// File: design/binary_trie_address_allocator_core.sv
// Sequence: a release of a free address ends at the leaf check, and an address outside
//   the pool is answered straight from idle; a release or a direct grant refreshes the
//   full marks up to the root, and a search climbs and descends before it does the same;
//   a held result adds its stall.
// Flow: one transaction at a time; tree memory with one write and one registered read port.
// Reset: synchronous active-low; then all 2^(ADDR_BITS+1) tree memory entries are cleared.
module binary_trie_address_allocator_core #(
  parameter int ADDR_BITS = btaa_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // address[7:0]
  input  logic [btaa_pkg::ADDR_FIELD_W-1:0] in_tdata,
  // operation[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], granted_address[9:2], allocated_count[18:10],
  // pool_empty[19], pool_full[20], zero[23:21]
  output logic [btaa_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int CW = ADDR_BITS + 1;

  btaa_pkg::req_t req;
  btaa_pkg::rsp_t rsp;
  logic           rsp_valid;
  logic           load;

  logic                                 out_valid_r;
  logic [CW-1:0]                        count_r, count_nxt;
  logic [btaa_pkg::STATUS_W-1:0]        status_r;
  logic [btaa_pkg::ADDR_FIELD_W-1:0]    granted_r;
  logic [btaa_pkg::COUNT_FIELD_W-1:0]   count_out_r;
  logic                                 empty_r;
  logic                                 full_r;

  assign req.op      = in_tuser;
  assign req.address = in_tdata;

  btaa_engine #(
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_take  (load)
  );

  // Take the engine answer when the output slot is free or draining
  always_comb begin
    load      = rsp_valid && (!out_valid_r || out_tready);
    count_nxt = count_r;
    if (rsp.status == btaa_pkg::ST_OK) begin
      if (rsp.op == btaa_pkg::OP_ALLOC) begin
        count_nxt = count_r + CW'(1);
      end else begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  // Output valid and allocated count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      status_r    <= rsp.status;
      granted_r   <= rsp.granted;
      count_out_r <= btaa_pkg::COUNT_FIELD_W'(count_nxt);
      empty_r     <= (count_nxt == '0);
      full_r      <= (count_nxt == {1'b1, {ADDR_BITS{1'b0}}});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, full_r, empty_r, count_out_r, granted_r, status_r};

endmodule

// File: design/btaa_checker.sv
module btaa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Clearing pass follows reset, so no transaction is taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == btaa_pkg::ST_OK ||
                    out_tdata[1:0] == btaa_pkg::ST_NO_FREE ||
                    out_tdata[1:0] == btaa_pkg::ST_NOT_TAKEN))
    else $error("undefined status code");

  // A failed transaction grants nothing
  a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != btaa_pkg::ST_OK) |-> out_tdata[9:2] == 8'd0)
    else $error("address granted on failure");

  // Pool cannot be empty and full at once
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[19] && out_tdata[20]))
    else $error("pool empty and full together");

endmodule

bind binary_trie_address_allocator_core btaa_checker u_btaa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: verif/tb_binary_trie_address_allocator_core.sv
`timescale 1ns / 1ps

module tb_binary_trie_address_allocator_core;

  localparam int POOL_SIZE  = 1 << btaa_pkg::ADDR_BITS_DEF;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 80;
  localparam int PRINT_MAX  = 100;

  // One expected answer of the allocator, compared field by field with out_tdata
  typedef struct packed {
    logic [btaa_pkg::STATUS_W-1:0]      status;
    logic [btaa_pkg::ADDR_FIELD_W-1:0]  granted;
    logic [btaa_pkg::COUNT_FIELD_W-1:0] count;
    logic                               empty;
    logic                               full;
  } pool_answer_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [btaa_pkg::ADDR_FIELD_W-1:0] in_tdata = '0;
  logic                              in_tuser = btaa_pkg::OP_ALLOC;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [btaa_pkg::OUT_DATA_W-1:0]   out_tdata;

  // Shadow of the pool
  bit [POOL_SIZE-1:0] pool_taken;
  int                 pool_count;
  pool_answer_t       pending_answers[$];
  pool_answer_t       oldest_answer;

  // Idle rates in percent
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Bookkeeping
  int error_count   = 0;
  int requests_sent = 0;
  int answers_seen  = 0;
  int grants        = 0;
  int climb_grants  = 0;
  int no_free_count = 0;
  int bad_releases  = 0;
  int peak_count    = 0;
  int stall_cycles  = 0;

  binary_trie_address_allocator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow pool and return the answer it should give
  function automatic pool_answer_t predict_pool_answer(logic op,
                                                       logic [btaa_pkg::ADDR_FIELD_W-1:0] addr);
    pool_answer_t ans;
    int           slot;
    ans.status  = btaa_pkg::ST_OK;
    ans.granted = '0;
    slot        = -1;
    if (op == btaa_pkg::OP_ALLOC) begin
      // lowest free address at or above the request
      for (int a = int'(addr); a < POOL_SIZE; a++) begin
        if (slot < 0 && !pool_taken[a]) slot = a;
      end
      if (slot >= 0) begin
        pool_taken[slot] = 1'b1;
        pool_count++;
        ans.granted = slot[btaa_pkg::ADDR_FIELD_W-1:0];
        grants++;
        if (slot != int'(addr)) climb_grants++;
      end else begin
        ans.status = btaa_pkg::ST_NO_FREE;
        no_free_count++;
      end
    end else begin
      if (int'(addr) < POOL_SIZE && pool_taken[addr]) begin
        pool_taken[addr] = 1'b0;
        pool_count--;
      end else begin
        ans.status = btaa_pkg::ST_NOT_TAKEN;
        bad_releases++;
      end
    end
    if (pool_count > peak_count) peak_count = pool_count;
    ans.count = pool_count[btaa_pkg::COUNT_FIELD_W-1:0];
    ans.empty = (pool_count == 0);
    ans.full  = (pool_count == POOL_SIZE);
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (error_count < PRINT_MAX)
      $display("ERROR @%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  // Send one request; the answer is predicted when the transaction is accepted
  task automatic send_request(input logic op, input logic [btaa_pkg::ADDR_FIELD_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    pending_answers.push_back(predict_pool_answer(op, addr));
    requests_sent++;
  endtask

  // Some taken address, or -1 when the pool is empty
  function automatic int pick_taken();
    int start;
    start = int'($urandom_range(POOL_SIZE - 1));
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (pool_taken[(start + i) % POOL_SIZE]) return (start + i) % POOL_SIZE;
    end
    return -1;
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every accepted answer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with nothing pending", 32'd0, 32'(out_tdata));
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_tdata[1:0] !== oldest_answer.status)
          report_mismatch("status", 32'(oldest_answer.status), 32'(out_tdata[1:0]));
        if (out_tdata[9:2] !== oldest_answer.granted)
          report_mismatch("granted_address", 32'(oldest_answer.granted),
                          32'(out_tdata[9:2]));
        if (out_tdata[18:10] !== oldest_answer.count)
          report_mismatch("allocated_count", 32'(oldest_answer.count),
                          32'(out_tdata[18:10]));
        if (out_tdata[19] !== oldest_answer.empty)
          report_mismatch("pool_empty", 32'(oldest_answer.empty), 32'(out_tdata[19]));
        if (out_tdata[20] !== oldest_answer.full)
          report_mismatch("pool_full", 32'(oldest_answer.full), 32'(out_tdata[20]));
        if (out_tdata[23:21] !== 3'b000)
          report_mismatch("pad bits", 32'd0, 32'(out_tdata[23:21]));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long
  initial begin
    while (stall_cycles < STALL_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", STALL_MAX);
    $display("Regression FAIL");
    $finish;
  end

  // Hand-picked requests: edges of the address range, climbs, holes, bad releases
  task automatic test_directed();
    send_request(btaa_pkg::OP_RELEASE, 8'd0);    // release on an empty pool
    send_request(btaa_pkg::OP_ALLOC, 8'd0);      // direct grant
    send_request(btaa_pkg::OP_ALLOC, 8'd0);      // taken, next one up
    send_request(btaa_pkg::OP_ALLOC, 8'd255);    // top address
    send_request(btaa_pkg::OP_ALLOC, 8'd255);    // nothing above the top
    send_request(btaa_pkg::OP_ALLOC, 8'd254);
    send_request(btaa_pkg::OP_ALLOC, 8'd254);    // both top slots taken
    send_request(btaa_pkg::OP_RELEASE, 8'd255);
    send_request(btaa_pkg::OP_RELEASE, 8'd255);  // second release of the same address
    send_request(btaa_pkg::OP_ALLOC, 8'd127);
    send_request(btaa_pkg::OP_ALLOC, 8'd127);    // crosses the root to the upper half
    send_request(btaa_pkg::OP_ALLOC, 8'd127);
    send_request(btaa_pkg::OP_ALLOC, 8'h55);
    send_request(btaa_pkg::OP_ALLOC, 8'hAA);
    send_request(btaa_pkg::OP_RELEASE, 8'd1);
    send_request(btaa_pkg::OP_ALLOC, 8'd0);      // refills the hole
    send_request(btaa_pkg::OP_RELEASE, 8'd128);
    send_request(btaa_pkg::OP_ALLOC, 8'd100);    // free, granted directly
    send_request(btaa_pkg::OP_RELEASE, 8'h55);
    send_request(btaa_pkg::OP_RELEASE, 8'hAA);
    send_request(btaa_pkg::OP_RELEASE, 8'h7F);
    send_request(btaa_pkg::OP_ALLOC, 8'd255);
  endtask

  // Fill the pool completely, probe the full pool, then drain in random order
  task automatic test_fill_and_drain();
    int order[POOL_SIZE];
    int j;
    int tmp;
    while (pool_count < POOL_SIZE) send_request(btaa_pkg::OP_ALLOC, 8'd0);
    send_request(btaa_pkg::OP_ALLOC, 8'd0);
    send_request(btaa_pkg::OP_ALLOC,
                 btaa_pkg::ADDR_FIELD_W'($urandom_range(POOL_SIZE - 1)));
    tmp = int'($urandom_range(POOL_SIZE - 1));
    send_request(btaa_pkg::OP_RELEASE, btaa_pkg::ADDR_FIELD_W'(tmp));
    send_request(btaa_pkg::OP_ALLOC, 8'd0);      // the only free slot
    for (int i = 0; i < POOL_SIZE; i++) order[i] = i;
    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j        = int'($urandom_range(i));
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < POOL_SIZE; i++)
      send_request(btaa_pkg::OP_RELEASE, btaa_pkg::ADDR_FIELD_W'(order[i]));
    send_request(btaa_pkg::OP_RELEASE, btaa_pkg::ADDR_FIELD_W'(order[0]));
  endtask

  // Random traffic; the fill bias changes every segment so occupancy wanders
  task automatic test_random_traffic(input int n);
    int fill_pct;
    int pick;
    int addr;
    fill_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: fill_pct = 15;
          1: fill_pct = 50;
          2: fill_pct = 85;
          default: fill_pct = 97;
        endcase
      end
      pick = int'($urandom_range(99));
      if (pick < 10) begin
        // noise: any op, any address
        send_request(logic'($urandom_range(1)),
                     btaa_pkg::ADDR_FIELD_W'($urandom_range(POOL_SIZE - 1)));
      end else if ($urandom_range(99) < fill_pct) begin
        // allocate, often right at a taken address to force a search
        addr = pick_taken();
        if (addr < 0 || $urandom_range(1)) addr = int'($urandom_range(POOL_SIZE - 1));
        send_request(btaa_pkg::OP_ALLOC, btaa_pkg::ADDR_FIELD_W'(addr));
      end else begin
        addr = pick_taken();
        if (addr < 0) addr = int'($urandom_range(POOL_SIZE - 1));
        send_request(btaa_pkg::OP_RELEASE, btaa_pkg::ADDR_FIELD_W'(addr));
      end
    end
  endtask

  initial begin
    pool_taken = '0;
    pool_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // slow receiver
    send_idle_pct = 19;
    recv_idle_pct = 86;
    test_directed();
    test_random_traffic(300);

    // slow sender
    send_idle_pct = 86;
    recv_idle_pct = 19;
    test_fill_and_drain();
    test_random_traffic(300);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);

    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests, checked %0d answers, %0d mismatches", requests_sent,
             answers_seen, error_count);
    $display("Grants %0d (%0d found by search), no-free %0d, bad releases %0d, peak use %0d",
             grants, climb_grants, no_free_count, bad_releases, peak_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
